// ----- sv/esw_pkg.sv -----
package esw_pkg;

    localparam int WINDOW_DEF  = 8;
    localparam int LOSS_W      = 32;
    localparam int EPOCH_W     = 16;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 88;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic walk_rd;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic cmp;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic fill_full;
        logic walk_last;
        logic out_busy;
    } t_status;

endpackage

// ----- sv/esw_ctrl.sv -----
module esw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  esw_pkg::t_status i_status,
    output esw_pkg::t_cmd   o_cmd
);
    import esw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    // no stop test while the window is still filling
                    n_state = i_status.fill_full ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                o_cmd.walk_rd = 1'b1;
                if (i_status.walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_MUL_A;
            ST_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = ST_MUL_C;
            end
            ST_MUL_C: begin
                o_cmd.mul_c = 1'b1;
                n_state     = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- sv/esw_dp.sv -----
module esw_dp #(
    parameter int WINDOW = esw_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  esw_pkg::t_cmd                   i_cmd,
    output esw_pkg::t_status                o_status,
    input  logic [esw_pkg::IN_TDATA_W-1:0]  i_tdata,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [esw_pkg::OUT_TDATA_W-1:0] o_tdata
);
    import esw_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MW = $clog2(WINDOW + 1);
    localparam int SW = LOSS_W + MW;
    localparam int LW = 2 * LOSS_W + MW;
    localparam int CW = 2 * LOSS_W + MW + 3;
    localparam logic [MW-1:0] W_K   = MW'(WINDOW);
    localparam logic [IW-1:0] IDX_L = IW'(WINDOW - 1);

    logic [LOSS_W-1:0] r_win [WINDOW];

    logic [MW-1:0]      r_fill;
    logic [IW-1:0]      r_oldest;
    logic [LOSS_W-1:0]  r_best_loss;
    logic [LOSS_W-1:0]  r_best_err;
    logic [EPOCH_W-1:0] r_best_ep;
    logic               r_stop;
    logic [LOSS_W-1:0]  r_x;

    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic [LOSS_W-1:0]  r_rd_data;
    logic               r_first;
    logic [SW-1:0]      r_sum;
    logic [LOSS_W-1:0]  r_min;

    logic [SW-1:0]       r_diff;
    logic [2*LOSS_W-1:0] r_prod;
    logic [2*LOSS_W-1:0] r_rhs;
    logic [LW-1:0]       r_lhs;

    logic               r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out;

    logic [LOSS_W-1:0]  in_loss;
    logic [LOSS_W-1:0]  in_err;
    logic [EPOCH_W-1:0] in_ep;
    logic [LOSS_W-1:0]  x_raised;
    logic               fill_full;
    logic [IW-1:0]      wr_addr;
    logic [LOSS_W-1:0]  mul_a;
    logic [LOSS_W-1:0]  mul_b;
    logic [2*LOSS_W-1:0] mul_p;
    logic [CW-1:0]      rhs_full;

    assign in_loss  = i_tdata[LOSS_W-1:0];
    assign in_err   = i_tdata[2*LOSS_W-1:LOSS_W];
    assign in_ep    = i_tdata[2*LOSS_W+EPOCH_W-1:2*LOSS_W];
    assign x_raised = (in_loss == '0) ? LOSS_W'(1) : in_loss;
    assign fill_full = (r_fill == W_K);
    assign wr_addr  = fill_full ? r_oldest : r_fill[IW-1:0];

    // one shared 32x32 multiplier, operands picked by step
    always_comb begin
        mul_a = r_x - r_best_loss;
        mul_b = r_min;
        if (i_cmd.mul_b) begin
            mul_a = r_diff[LOSS_W-1:0];
            mul_b = r_best_loss;
        end else if (i_cmd.mul_c) begin
            mul_a = LOSS_W'(r_diff[SW-1:LOSS_W]);
            mul_b = r_best_loss;
        end
    end
    assign mul_p = (2*LOSS_W)'(mul_a) * (2*LOSS_W)'(mul_b);

    assign rhs_full = ((CW'(r_prod) << LOSS_W) + CW'(r_rhs)) << 3;

    assign o_status.fill_full = fill_full;
    assign o_status.walk_last = (r_rd_idx == IDX_L);
    assign o_status.out_busy  = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_win[wr_addr] <= x_raised;
        end
        r_rd_data <= r_win[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_oldest    <= '0;
            r_best_loss <= '0;
            r_best_err  <= '0;
            r_best_ep   <= '0;
            r_stop      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.walk_rd;
            if (i_cmd.accept) begin
                r_x      <= x_raised;
                r_rd_idx <= '0;
                r_first  <= 1'b1;
                r_sum    <= '0;
                if (r_fill == '0 || r_best_loss > x_raised) begin
                    r_best_loss <= x_raised;
                    r_best_err  <= in_err;
                    r_best_ep   <= in_ep;
                end
                if (fill_full) begin
                    r_oldest <= (r_oldest == IDX_L) ? '0 : r_oldest + IW'(1);
                end else begin
                    r_fill <= r_fill + MW'(1);
                end
            end
            if (i_cmd.walk_rd) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
            if (r_rd_vld) begin
                r_first <= 1'b0;
                r_sum   <= r_sum + SW'(r_rd_data);
                if (r_first || r_rd_data < r_min) begin
                    r_min <= r_rd_data;
                end
            end
            if (i_cmd.mul_a) begin
                r_prod <= mul_p;
                r_diff <= r_sum - SW'(r_min) * SW'(W_K);
            end
            if (i_cmd.mul_b) begin
                r_lhs  <= LW'(r_prod) * LW'(W_K);
                r_prod <= mul_p;
            end
            if (i_cmd.mul_c) begin
                r_rhs  <= r_prod;
                r_prod <= mul_p;
            end
            if (i_cmd.cmp && (CW'(r_lhs) > rhs_full)) begin
                r_stop <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= {6'd0, fill_full, r_best_ep, r_best_err, r_best_loss, r_stop};
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out;

endmodule

// ----- sv/early_stop_window_monitor.sv -----
// Channel | Dir | Handshake                 | Payload (lowest bit first)
// s       | in  | i_s_tvalid / o_s_tready   | loss 32, error_value 32, epoch 16
// m       | out | o_m_tvalid / i_m_tready   | stop 1, best_loss 32, best_error 32,
//         |     |                           | best_epoch 16, window_full 1, pad 6
//
// An item that arrives while the window is still filling goes from accept
// straight to the result load. Once the window is full an item first runs the
// min/sum walk, reading the window memory one entry per cycle; then a shared
// 32x32 multiplier runs three steps before the final compare.
// Reset (i_rst_n low, synchronous) clears the fill count, best record and stop.
// A result held on the m side does not block the next accept; the block waits
// only when a new result is ready and the previous one was not yet taken.
module early_stop_window_monitor #(
    parameter int WINDOW = esw_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // loss [31:0], error_value [63:32], epoch [79:64]
    input  logic [esw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // stop [0], best_loss [32:1], best_error [64:33], best_epoch [80:65],
    // window_full [81], zero [87:82]
    output logic [esw_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import esw_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequence accept, window walk, multiply steps and result load
    esw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // window memory, best record, min/sum accumulators and the stop test
    esw_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_tdata  (i_s_tdata),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata)
    );

endmodule
